[rtl/core/cads_pkg.sv]
`timescale 1ns / 1ps
package cads_pkg;

    // function codes carried in s_axis tuser
    typedef enum logic [3:0] {
        FN_CYCLE      = 4'd0,
        FN_SERVO_ON   = 4'd1,
        FN_SERVO_OFF  = 4'd2,
        FN_GO_HOME    = 4'd3,
        FN_TARGET_POS = 4'd4,
        FN_TARGET_VEL = 4'd5,
        FN_HALT       = 4'd6,
        FN_QUICK_STOP = 4'd7,
        FN_ENDLESS    = 4'd8
    } t_func;

    localparam logic [2:0] SS_DISC   = 3'd0;
    localparam logic [2:0] SS_OFF    = 3'd1;
    localparam logic [2:0] SS_IDLE   = 3'd2;
    localparam logic [2:0] SS_RUN    = 3'd3;
    localparam logic [2:0] SS_HOMING = 3'd4;
    localparam logic [2:0] SS_STOP   = 3'd5;
    localparam logic [2:0] SS_FAULT  = 3'd6;

    localparam logic [3:0] DS_NRTSO = 4'd0;
    localparam logic [3:0] DS_SOD   = 4'd1;
    localparam logic [3:0] DS_RTSO  = 4'd2;
    localparam logic [3:0] DS_SON   = 4'd3;
    localparam logic [3:0] DS_OE    = 4'd4;
    localparam logic [3:0] DS_QSA   = 4'd5;
    localparam logic [3:0] DS_FRA   = 4'd6;
    localparam logic [3:0] DS_FAULT = 4'd7;
    localparam logic [3:0] DS_UNK   = 4'd8;

    localparam logic [7:0] M_PP   = 8'd1;
    localparam logic [7:0] M_PV   = 8'd3;
    localparam logic [7:0] M_HOME = 8'd6;
    localparam logic [7:0] M_CSP  = 8'd8;
    localparam logic [7:0] M_CSV  = 8'd9;
    localparam logic [7:0] M_CST  = 8'd10;

    localparam logic [15:0] CW_SHUTDOWN = 16'h0006;
    localparam logic [15:0] CW_SWON     = 16'h0007;
    localparam logic [15:0] CW_ENABLE   = 16'h000F;
    localparam logic [15:0] CW_FRESET   = 16'h0080;
    localparam logic [15:0] CW_DISVOLT  = 16'h0000;
    localparam logic [15:0] CW_QSTOP    = 16'h0002;

    // control flag bit positions
    localparam int CF_ONOFF   = 0;
    localparam int CF_TRIG    = 1;
    localparam int CF_SETHOME = 2;
    localparam int CF_HALT    = 3;
    localparam int CF_ENDLESS = 4;
    localparam int CF_REL     = 5;
    localparam int CF_SERVO   = 6;
    localparam int CF_FAULT   = 7;

    // motion flag bit positions
    localparam int MF_ACK    = 0;
    localparam int MF_TREACH = 1;
    localparam int MF_HREACH = 2;
    localparam int MF_HABORT = 3;
    localparam int MF_SZERO  = 4;
    localparam int MF_SAT    = 5;
    localparam int MF_FERR   = 6;
    localparam int MF_HSET   = 7;

    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] raw_status_word;
        logic [7:0]  actual_mode;
        logic [31:0] actual_position;
        logic        link_online;
        logic [31:0] command_value;
        logic        option_a;
        logic        option_b;
    } t_item;

    typedef struct packed {
        logic [2:0]  servo_status;
        logic [3:0]  drive_state;
        logic [15:0] control_word;
        logic [31:0] target_position;
        logic [31:0] target_velocity;
        logic [7:0]  requested_mode;
        logic [7:0]  observed_mode;
        logic [7:0]  control_flags;
        logic [7:0]  motion_flags;
    } t_state;

    function automatic logic [3:0] decode_state(input logic [15:0] sw);
        logic [7:0] a;
        logic [7:0] b;
        a = sw[7:0] & 8'h4F;
        b = sw[7:0] & 8'h6F;
        if (a == 8'h00)      return DS_NRTSO;
        else if (a == 8'h08) return DS_FAULT;
        else if (a == 8'h40) return DS_SOD;
        else if (b == 8'h27) return DS_OE;
        else if (b == 8'h23) return DS_SON;
        else if (b == 8'h21) return DS_RTSO;
        else if (b == 8'h07) return DS_QSA;
        else if (a == 8'h0F) return DS_FRA;
        else                 return DS_UNK;
    endfunction

endpackage

[rtl/core/cads_step.sv]
`timescale 1ns / 1ps
module cads_step (
    input  cads_pkg::t_item  i_item,
    input  cads_pkg::t_state i_state,
    output cads_pkg::t_state o_state,
    output logic             o_accepted
);

    cads_pkg::t_state s;
    logic [15:0] sw;
    logic [3:0]  ds;
    logic        halt;
    logic        servo_on;
    logic        forced;

    always_comb begin
        s        = i_state;
        sw       = i_item.raw_status_word;
        ds       = cads_pkg::decode_state(sw);
        halt     = i_state.control_flags[cads_pkg::CF_HALT];
        servo_on = i_state.control_flags[cads_pkg::CF_SERVO];
        forced   = 1'b0;
        o_accepted = 1'b1;

        unique case (i_item.func)
            cads_pkg::FN_CYCLE: begin
                // status analysis runs on the mode latched by the previous exchange
                if (!i_item.link_online) begin
                    s.servo_status = cads_pkg::SS_DISC;
                end else begin
                    s.motion_flags[cads_pkg::MF_HSET] = sw[15];
                    s.motion_flags[cads_pkg::MF_FERR] = sw[13];
                    case (i_state.observed_mode) inside
                        cads_pkg::M_PP: begin
                            s.motion_flags[cads_pkg::MF_TREACH] = 1'b0;
                            s.motion_flags[cads_pkg::MF_ACK]    = 1'b0;
                            if (halt) begin
                                s.servo_status = cads_pkg::SS_STOP;
                            end else begin
                                if (sw[12]) begin
                                    s.servo_status = cads_pkg::SS_RUN;
                                    s.motion_flags[cads_pkg::MF_ACK] = 1'b1;
                                end
                                if (sw[10]) begin
                                    s.servo_status = cads_pkg::SS_IDLE;
                                    s.motion_flags[cads_pkg::MF_TREACH] = 1'b1;
                                end
                            end
                        end
                        cads_pkg::M_HOME: begin
                            if (s.control_flags[cads_pkg::CF_SETHOME]) begin
                                s.control_word[4] = 1'b0;
                                s.control_flags[cads_pkg::CF_SETHOME] = 1'b0;
                            end
                            s.motion_flags[cads_pkg::MF_HREACH] = sw[12];
                            s.motion_flags[cads_pkg::MF_HABORT] = sw[10];
                            if (sw[12]) begin
                                s.servo_status   = cads_pkg::SS_IDLE;
                                s.requested_mode = cads_pkg::M_PP;
                            end else if (sw[10]) begin
                                s.servo_status = cads_pkg::SS_STOP;
                            end else if (s.control_flags[cads_pkg::CF_SERVO]) begin
                                s.servo_status = cads_pkg::SS_HOMING;
                            end
                        end
                        cads_pkg::M_PV: begin
                            if (halt) begin
                                s.servo_status = cads_pkg::SS_STOP;
                            end else if (sw[10]) begin
                                s.servo_status = cads_pkg::SS_IDLE;
                                s.motion_flags[cads_pkg::MF_TREACH] = 1'b1;
                            end else begin
                                s.motion_flags[cads_pkg::MF_TREACH] = 1'b0;
                                s.servo_status = cads_pkg::SS_RUN;
                            end
                            s.motion_flags[cads_pkg::MF_SZERO] = sw[11];
                            s.motion_flags[cads_pkg::MF_SAT]   = sw[12];
                        end
                        cads_pkg::M_CSV, cads_pkg::M_CSP, cads_pkg::M_CST: begin
                            s.servo_status = sw[12] ? cads_pkg::SS_RUN : cads_pkg::SS_IDLE;
                        end
                        default: ;
                    endcase
                end

                s.drive_state = ds;
                s.control_flags[cads_pkg::CF_SERVO] = (ds == cads_pkg::DS_OE);
                s.observed_mode = i_item.actual_mode;
                if (ds == cads_pkg::DS_FAULT) begin
                    s.control_flags[cads_pkg::CF_FAULT] = 1'b1;
                end else if (ds == cads_pkg::DS_SOD) begin
                    s.control_flags[cads_pkg::CF_FAULT] = 1'b0;
                end

                // control word sequencing
                if (s.control_flags[cads_pkg::CF_ONOFF] &&
                    !s.control_flags[cads_pkg::CF_SERVO]) begin
                    case (ds)
                        cads_pkg::DS_SOD: begin
                            s.servo_status = cads_pkg::SS_OFF;
                            s.control_word = cads_pkg::CW_SHUTDOWN;
                        end
                        cads_pkg::DS_RTSO: s.control_word = cads_pkg::CW_SWON;
                        cads_pkg::DS_SON: begin
                            s.target_position = i_item.actual_position;
                            s.target_velocity = '0;
                            s.control_word    = cads_pkg::CW_ENABLE;
                        end
                        cads_pkg::DS_FAULT: begin
                            s.servo_status = cads_pkg::SS_FAULT;
                            s.control_word = cads_pkg::CW_FRESET;
                        end
                        cads_pkg::DS_QSA: s.control_word = cads_pkg::CW_DISVOLT;
                        default: ;
                    endcase
                end else if (!s.control_flags[cads_pkg::CF_ONOFF]) begin
                    s.control_word = cads_pkg::CW_SHUTDOWN;
                    s.servo_status = cads_pkg::SS_OFF;
                end else begin
                    if (s.control_flags[cads_pkg::CF_TRIG] &&
                        s.observed_mode == cads_pkg::M_HOME) begin
                        if (s.control_flags[cads_pkg::CF_HALT]) begin
                            s.control_word[8] = 1'b0;
                            s.control_flags[cads_pkg::CF_HALT] = 1'b0;
                        end else begin
                            // homing start: plain new set point
                            s.control_word[5] = 1'b0;
                            s.control_word[4] = 1'b1;
                            s.control_flags[cads_pkg::CF_SETHOME] = 1'b1;
                            s.control_flags[cads_pkg::CF_TRIG]    = 1'b0;
                        end
                    end
                    if (s.observed_mode == cads_pkg::M_PP &&
                        s.motion_flags[cads_pkg::MF_ACK]) begin
                        s.control_word[5:4] = 2'b00;
                    end
                end
            end
            cads_pkg::FN_SERVO_ON: begin
                s.requested_mode = i_item.command_value[7:0];
                if (!servo_on) s.control_flags[cads_pkg::CF_ONOFF] = 1'b1;
            end
            cads_pkg::FN_SERVO_OFF: begin
                if (servo_on) s.control_flags[cads_pkg::CF_ONOFF] = 1'b0;
            end
            cads_pkg::FN_GO_HOME: begin
                s.requested_mode = cads_pkg::M_HOME;
                if (!servo_on) s.control_flags[cads_pkg::CF_ONOFF] = 1'b1;
                s.control_flags[cads_pkg::CF_TRIG] = 1'b1;
            end
            cads_pkg::FN_TARGET_POS: begin
                if (s.observed_mode != cads_pkg::M_CSP && s.observed_mode != cads_pkg::M_PP) begin
                    o_accepted = 1'b0;
                end else begin
                    forced = i_item.option_a || halt;
                    s.control_word[5] = (s.observed_mode == cads_pkg::M_PP) && forced;
                    s.control_word[4] = 1'b1;
                    if (forced) begin
                        s.control_word[8] = 1'b0;
                        s.control_flags[cads_pkg::CF_HALT] = 1'b0;
                    end
                    if (s.observed_mode == cads_pkg::M_PP) begin
                        s.control_word[6] = i_item.option_b;
                        s.control_flags[cads_pkg::CF_REL] = i_item.option_b;
                    end
                    s.target_position = i_item.command_value;
                end
            end
            cads_pkg::FN_TARGET_VEL: begin
                if (s.observed_mode != cads_pkg::M_CSV && s.observed_mode != cads_pkg::M_PV) begin
                    o_accepted = 1'b0;
                end else begin
                    s.target_velocity = i_item.command_value;
                    forced = i_item.option_a || halt;
                    s.control_word[5] = (s.observed_mode == cads_pkg::M_PP) && forced;
                    s.control_word[4] = 1'b1;
                    if (forced) begin
                        s.control_word[8] = 1'b0;
                        s.control_flags[cads_pkg::CF_HALT] = 1'b0;
                    end
                end
            end
            cads_pkg::FN_HALT: begin
                s.control_word[8] = i_item.option_a;
                s.control_flags[cads_pkg::CF_HALT] = i_item.option_a;
            end
            cads_pkg::FN_QUICK_STOP: begin
                s.control_word = cads_pkg::CW_QSTOP;
            end
            cads_pkg::FN_ENDLESS: begin
                if (s.observed_mode != cads_pkg::M_PP) begin
                    o_accepted = 1'b0;
                end else begin
                    s.control_word[15] = i_item.option_a;
                    s.control_flags[cads_pkg::CF_ENDLESS] = i_item.option_a;
                end
            end
            default: ;
        endcase

        o_state = s;
    end

endmodule

[rtl/core/cia402_axis_drive_sequencer_core.sv]
`timescale 1ns / 1ps
// A word taken at s_axis passes the input register, then the state update and the result
// register, before it appears on m_axis.
// Throughput: one word per cycle unless m_axis stalls; the axis state feeds back on itself.
// Reset (i_rst_n low, synchronous): both stages empty, axis state cleared to
// disconnected / not ready to switch on with zero process data and flags.
module cia402_axis_drive_sequencer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // raw_status_word[15:0], actual_mode[23:16], actual_position[55:24],
    // link_online[56], command_value[88:57], option_a[89], option_b[90], zero pad
    input  logic [95:0]  i_s_axis_tdata,
    // func[3:0]
    input  logic [3:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // control_word_out[15:0], target_position_out[47:16], target_velocity_out[79:48],
    // mode_out[87:80], servo_status[90:88], drive_state[94:91], servo_is_on[95],
    // fault_latched[96], command_accepted[97], motion_flags[105:98], zero pad
    output logic [111:0] o_m_axis_tdata
);

    cads_pkg::t_item  r_item;
    logic             r_in_valid;
    cads_pkg::t_state r_state;
    cads_pkg::t_state n_state;
    logic             n_accepted;
    logic             r_out_valid;
    logic [105:0]     r_out_data;
    logic             advance;

    // the result register frees up when downstream takes the word
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    cads_step u_step (
        .i_item     (r_item),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_accepted (n_accepted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{servo_status: cads_pkg::SS_DISC,
                             drive_state:  cads_pkg::DS_NRTSO,
                             default:      '0};
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.func            <= i_s_axis_tuser;
            r_item.raw_status_word <= i_s_axis_tdata[15:0];
            r_item.actual_mode     <= i_s_axis_tdata[23:16];
            r_item.actual_position <= i_s_axis_tdata[55:24];
            r_item.link_online     <= i_s_axis_tdata[56];
            r_item.command_value   <= i_s_axis_tdata[88:57];
            r_item.option_a        <= i_s_axis_tdata[89];
            r_item.option_b        <= i_s_axis_tdata[90];
        end
        if (advance) begin
            r_out_data <= {n_state.motion_flags,
                           n_accepted,
                           n_state.control_flags[cads_pkg::CF_FAULT],
                           n_state.control_flags[cads_pkg::CF_SERVO],
                           n_state.drive_state,
                           n_state.servo_status,
                           n_state.requested_mode,
                           n_state.target_velocity,
                           n_state.target_position,
                           n_state.control_word};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_data};

endmodule
